// ===== hw/rtl/tfr_pkg.sv =====
// package: frame codes, field widths and shared types for the typed frame receiver
`timescale 1ns / 1ps

package tfr_pkg;

   localparam int ACK_CHARS   = 3;
   localparam int NUMBER_BITS = 16;
   localparam int BYTE_BITS   = 8;
   localparam int SCAP_BITS   = 9;
   localparam int NCAP_BITS   = 4;
   localparam int CSR_DATA_BITS = SCAP_BITS;
   localparam int COUNT_BITS  = 8;

   localparam logic [BYTE_BITS-1:0] CHAR_OPEN_STRING = 8'h53;  // 'S'
   localparam logic [BYTE_BITS-1:0] CHAR_OPEN_NUMBER = 8'h4E;  // 'N'
   localparam logic [BYTE_BITS-1:0] CHAR_OPEN_ACK    = 8'h41;  // 'A'
   localparam logic [BYTE_BITS-1:0] CHAR_CLOSE       = 8'h00;
   localparam logic [BYTE_BITS-1:0] CHAR_DIGIT_ZERO  = 8'd48;
   localparam logic [NUMBER_BITS-1:0] DIGIT_BASE     = NUMBER_BITS'(10);

   localparam logic [SCAP_BITS-1:0] STRING_CAP_RESET = SCAP_BITS'(32);
   localparam logic [NCAP_BITS-1:0] NUMBER_CAP_RESET = NCAP_BITS'(6);

   typedef enum logic [0:0] {
      CSR_STRING_CAPACITY = 1'b0,
      CSR_NUMBER_CAPACITY = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      FRAME_STRING = 2'd0,
      FRAME_NUMBER = 2'd1,
      FRAME_ACK    = 2'd2
   } frame_kind_type;

   typedef enum logic [1:0] {
      EV_STRING_BYTE = 2'd0,
      EV_STRING_DONE = 2'd1,
      EV_NUMBER_DONE = 2'd2,
      EV_ACK_DONE    = 2'd3
   } event_kind_type;

   typedef struct packed {
      event_kind_type         event_kind;
      logic [7:0]             position;
      logic [BYTE_BITS-1:0]   char_byte;
      logic [7:0]             string_length;
      logic [NUMBER_BITS-1:0] number_value;
      logic                   ack_valid;
   } event_type;

   typedef struct packed {
      logic      valid;
      event_type ev;
   } result_type;

   // kept-byte limit: capacity minus one, zero for capacities below one, capped at 255
   function automatic logic [COUNT_BITS-1:0] string_limit(input logic [SCAP_BITS-1:0] cap);
      logic [SCAP_BITS-1:0] lim;
      lim = (cap == '0) ? '0 : cap - SCAP_BITS'(1);
      return (lim > SCAP_BITS'(255)) ? COUNT_BITS'(255) : lim[COUNT_BITS-1:0];
   endfunction

   function automatic logic [NCAP_BITS-1:0] number_limit(input logic [NCAP_BITS-1:0] cap);
      return (cap == '0) ? '0 : cap - NCAP_BITS'(1);
   endfunction

   function automatic logic [BYTE_BITS-1:0] ack_char(input logic [1:0] idx);
      logic [BYTE_BITS-1:0] c;
      case (idx)
         2'd0:    c = 8'h41;  // 'A'
         2'd1:    c = 8'h63;  // 'c'
         2'd2:    c = 8'h6B;  // 'k'
         default: c = 8'h41;
      endcase
      return c;
   endfunction

endpackage

// ===== hw/rtl/tfr_channels.sv =====
// interfaces: byte input channel, event result channel and register write channel
`timescale 1ns / 1ps

interface tfr_byte_if;
   import tfr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tfr_event_if;
   import tfr_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [1:0]             event_kind;
   logic [7:0]             position;
   logic [BYTE_BITS-1:0]   char_byte;
   logic [7:0]             string_length;
   logic [NUMBER_BITS-1:0] number_value;
   logic                   ack_valid;
   modport source (output valid, output event_kind, output position, output char_byte,
                   output string_length, output number_value, output ack_valid,
                   input ready);
   modport sink   (input valid, input event_kind, input position, input char_byte,
                   input string_length, input number_value, input ack_valid,
                   output ready);
endinterface

interface tfr_csr_if;
   import tfr_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     index;
   logic [CSR_DATA_BITS-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/tfr_parser.sv =====
// frame parser: input byte register, frame state and per-byte result logic
`timescale 1ns / 1ps

module tfr_parser
   import tfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   tfr_byte_if.sink              req_ch,
   input  logic [COUNT_BITS-1:0] string_limit_i,
   input  logic [NCAP_BITS-1:0]  number_limit_i,
   input  logic                  out_free,
   output result_type            result
);

   logic                   in_valid_ff, in_valid_in;
   logic [BYTE_BITS-1:0]   in_byte_ff, in_byte_in;
   logic                   in_frame_ff, in_frame_in;
   frame_kind_type         frame_ff, frame_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [NUMBER_BITS-1:0] sum_ff, sum_in;
   logic [NUMBER_BITS-1:0] weight_ff, weight_in;
   logic [ACK_CHARS-1:0]   match_ff, match_in;

   logic                   advance;
   logic                   take;
   logic [NUMBER_BITS-1:0] digit;
   logic [NUMBER_BITS-1:0] product;
   result_type             res;

   assign advance      = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign take         = req_ch.valid && req_ch.ready;

   assign digit   = NUMBER_BITS'(in_byte_ff) - NUMBER_BITS'(CHAR_DIGIT_ZERO);
   assign product = NUMBER_BITS'(digit * weight_ff);

   always_comb begin
      in_valid_in = take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_byte_in  = take ? req_ch.rx_byte : in_byte_ff;
      in_frame_in = in_frame_ff;
      frame_in    = frame_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      weight_in   = weight_ff;
      match_in    = match_ff;
      res         = '0;
      if (advance) begin
         if (!in_frame_ff) begin
            if (in_byte_ff == CHAR_OPEN_STRING || in_byte_ff == CHAR_OPEN_NUMBER ||
                in_byte_ff == CHAR_OPEN_ACK) begin
               in_frame_in = 1'b1;
               frame_in    = (in_byte_ff == CHAR_OPEN_STRING) ? FRAME_STRING :
                             (in_byte_ff == CHAR_OPEN_NUMBER) ? FRAME_NUMBER : FRAME_ACK;
               count_in    = '0;
               sum_in      = '0;
               weight_in   = NUMBER_BITS'(1);
               match_in    = '0;
            end
         end else if (in_byte_ff == CHAR_CLOSE) begin
            in_frame_in = 1'b0;
            res.valid   = 1'b1;
            case (frame_ff)
               FRAME_STRING: begin
                  res.ev.event_kind    = EV_STRING_DONE;
                  res.ev.string_length = count_ff;
               end
               FRAME_NUMBER: begin
                  res.ev.event_kind   = EV_NUMBER_DONE;
                  res.ev.number_value = sum_ff;
               end
               default: begin
                  res.ev.event_kind = EV_ACK_DONE;
                  res.ev.ack_valid  = &match_ff;
               end
            endcase
         end else begin
            case (frame_ff)
               FRAME_STRING: begin
                  if (count_ff < string_limit_i) begin
                     res.valid          = 1'b1;
                     res.ev.event_kind  = EV_STRING_BYTE;
                     res.ev.position    = count_ff;
                     res.ev.char_byte   = in_byte_ff;
                     count_in           = count_ff + COUNT_BITS'(1);
                  end
               end
               FRAME_NUMBER: begin
                  if (count_ff < COUNT_BITS'(number_limit_i)) begin
                     sum_in    = sum_ff + product;
                     weight_in = NUMBER_BITS'(weight_ff * DIGIT_BASE);
                     count_in  = count_ff + COUNT_BITS'(1);
                  end
               end
               default: begin
                  // only the first ACK_CHARS ack bytes are compared
                  if (count_ff < COUNT_BITS'(ACK_CHARS)) begin
                     if (in_byte_ff == ack_char(count_ff[1:0])) begin
                        match_in[count_ff[1:0]] = 1'b1;
                     end
                     count_in = count_ff + COUNT_BITS'(1);
                  end
               end
            endcase
         end
      end
   end

   assign result = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         in_frame_ff <= 1'b0;
         frame_ff    <= FRAME_STRING;
         count_ff    <= '0;
         sum_ff      <= '0;
         weight_ff   <= NUMBER_BITS'(1);
         match_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         in_frame_ff <= in_frame_in;
         frame_ff    <= frame_in;
         count_ff    <= count_in;
         sum_ff      <= sum_in;
         weight_ff   <= weight_in;
         match_ff    <= match_in;
      end
      in_byte_ff <= in_byte_in;
   end

endmodule

// ===== hw/rtl/tfr_rsp_buffer.sv =====
// result register: holds one event until the receiver takes it
`timescale 1ns / 1ps

module tfr_rsp_buffer
   import tfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  result_type result,
   output logic       out_free,
   tfr_event_if.source rsp_ch
);

   logic      valid_ff, valid_in;
   event_type ev_ff, ev_in;

   // free when empty or being drained in this cycle
   assign out_free = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff && !rsp_ch.ready;
      ev_in    = ev_ff;
      if (result.valid) begin
         valid_in = 1'b1;
         ev_in    = result.ev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      ev_ff <= ev_in;
   end

   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.event_kind    = ev_ff.event_kind;
   assign rsp_ch.position      = ev_ff.position;
   assign rsp_ch.char_byte     = ev_ff.char_byte;
   assign rsp_ch.string_length = ev_ff.string_length;
   assign rsp_ch.number_value  = ev_ff.number_value;
   assign rsp_ch.ack_valid     = ev_ff.ack_valid;

endmodule

// ===== hw/rtl/typed_frame_receiver_unit.sv =====
// top level: typed frame receiver with capacity registers, parser and result register
`timescale 1ns / 1ps
//
// req_ch carries received bytes, one per transfer. Outside a frame 'S', 'N'
// or 'A' opens a string, number or ack frame; other bytes are dropped. A
// zero byte closes the open frame.
// rsp_ch carries events: a stored string byte with its position, string
// done with its length, number done with its value (digits least
// significant first, modulo 65536), ack done with the match flag.
// csr_ch writes the string capacity (index 0) and number capacity
// (index 1); it is always ready and is meant to be used while idle.
// An accepted byte first enters the input register; its event, if any,
// then passes through the result register onto rsp_ch.
// Throughput: one byte per cycle while rsp_ch does not stall; the frame
// state update (one 16x16 multiply plus add for number digits) is combinational.
// Reset clears the frame state and loads capacities 32 and 6; no event is
// pending afterwards. When the receiver stalls rsp_ch, one event waits in
// the result register, one byte in the input register, and req_ch.ready
// drops only once both are full.
//

module typed_frame_receiver_unit
   import tfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tfr_byte_if.sink    req_ch,
   tfr_event_if.source rsp_ch,
   tfr_csr_if.sink     csr_ch
);

   logic [COUNT_BITS-1:0] string_limit_ff, string_limit_in;
   logic [NCAP_BITS-1:0]  number_limit_ff, number_limit_in;
   logic                  out_free;
   result_type            result;

   assign csr_ch.ready = 1'b1;

   // capacities are stored as kept-byte limits
   always_comb begin
      string_limit_in = string_limit_ff;
      number_limit_in = number_limit_ff;
      if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_STRING_CAPACITY: string_limit_in = string_limit(csr_ch.data);
            CSR_NUMBER_CAPACITY: number_limit_in = number_limit(csr_ch.data[NCAP_BITS-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         string_limit_ff <= string_limit(STRING_CAP_RESET);
         number_limit_ff <= number_limit(NUMBER_CAP_RESET);
      end else begin
         string_limit_ff <= string_limit_in;
         number_limit_ff <= number_limit_in;
      end
   end

   tfr_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .string_limit_i (string_limit_ff),
      .number_limit_i (number_limit_ff),
      .out_free       (out_free),
      .result         (result)
   );

   tfr_rsp_buffer u_rsp_buffer (
      .clock    (clock),
      .reset    (reset),
      .result   (result),
      .out_free (out_free),
      .rsp_ch   (rsp_ch)
   );

   a_store_in_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.event_kind == EV_STRING_BYTE) |->
         (rsp_ch.position < string_limit_ff))
      else $error("string byte stored beyond the kept limit");

   a_length_in_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.event_kind == EV_STRING_DONE) |->
         (rsp_ch.string_length <= string_limit_ff))
      else $error("string length exceeds the kept limit");

   a_unused_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.event_kind == EV_ACK_DONE) |->
         (rsp_ch.position == '0 && rsp_ch.char_byte == '0 &&
          rsp_ch.string_length == '0 && rsp_ch.number_value == '0))
      else $error("ack event carries nonzero fields of other kinds");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!rsp_ch.valid && req_ch.ready))
      else $error("pipeline not empty after reset");

endmodule

// ===== test/typed_frame_receiver_unit_tb.sv =====
// testbench: typed frame receiver driven with framed byte streams, events checked against a predictor
`timescale 1ns / 1ps

module typed_frame_receiver_unit_tb;
   import tfr_pkg::*;

   localparam int CYCLE_LIMIT      = 1000000;
   localparam int ITEM_TARGET      = 1150;
   localparam int PHASE_ITEMS      = 100;
   localparam int SETTLE_CYCLES    = 4;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int HOLD_PHASE       = 4;
   localparam int LONG_STRING_PHASE = 5;
   localparam int PLAN_PHASES      = 9;

   localparam logic [7:0] ACK_WORD [3] = '{8'h41, 8'h63, 8'h6B};

   localparam int STRING_CAP_PLAN [PLAN_PHASES] = '{32, 2, 0, 1, 256, 511, 257, 255, 3};
   localparam int NUMBER_CAP_PLAN [PLAN_PHASES] = '{6, 2, 0, 1, 8, 15, 7, 3, 14};

   // zero outside a frame, a string with 0xff and a frame opener as data, a number,
   // a number that wraps, a good ack, an empty string
   localparam logic [7:0] OPENING_BYTES [25] = '{
      CHAR_CLOSE,
      CHAR_OPEN_STRING, 8'h01, 8'hFF, CHAR_OPEN_NUMBER, CHAR_CLOSE,
      CHAR_OPEN_NUMBER, "1", "2", "3", CHAR_CLOSE,
      CHAR_OPEN_NUMBER, "9", "9", "9", "9", "9", CHAR_CLOSE,
      CHAR_OPEN_ACK, "A", "c", "k", CHAR_CLOSE,
      CHAR_OPEN_STRING, CHAR_CLOSE
   };

   class frame_scoreboard;
      int errors;
      event_type expected_events[$];
      logic [8:0] string_cap;
      logic [3:0] number_cap;
      bit in_frame;
      frame_kind_type kind;
      logic [7:0] kept;
      logic [15:0] sum;
      logic [15:0] weight;
      logic [2:0] ack_hits;

      function new();
         errors = 0;
         string_cap = STRING_CAP_RESET;
         number_cap = NUMBER_CAP_RESET;
         in_frame = 1'b0;
         kind = FRAME_STRING;
         start_frame();
      endfunction

      function void start_frame();
         kept = '0;
         sum = '0;
         weight = 16'd1;
         ack_hits = '0;
      endfunction

      function logic [7:0] string_keep_limit();
         if (string_cap == 9'd0) return 8'd0;
         if (string_cap > 9'd256) return 8'd255;
         return 8'(string_cap - 9'd1);
      endfunction

      function logic [7:0] number_keep_limit();
         return (number_cap == 4'd0) ? 8'd0 : {4'd0, number_cap - 4'd1};
      endfunction

      function void write_capacity(csr_index_type idx, logic [8:0] value);
         if (idx == CSR_STRING_CAPACITY) string_cap = value;
         else number_cap = value[3:0];
      endfunction

      function int pending();
         return expected_events.size();
      endfunction

      function void note_byte(logic [7:0] b);
         event_type ev;
         bit produce;
         logic [15:0] digit;
         ev = '0;
         produce = 1'b0;
         if (!in_frame) begin
            if (b == CHAR_OPEN_STRING || b == CHAR_OPEN_NUMBER || b == CHAR_OPEN_ACK) begin
               in_frame = 1'b1;
               kind = (b == CHAR_OPEN_STRING) ? FRAME_STRING :
                      (b == CHAR_OPEN_NUMBER) ? FRAME_NUMBER : FRAME_ACK;
               start_frame();
            end
         end else if (b == CHAR_CLOSE) begin
            in_frame = 1'b0;
            produce = 1'b1;
            case (kind)
               FRAME_STRING: begin
                  ev.event_kind = EV_STRING_DONE;
                  ev.string_length = kept;
               end
               FRAME_NUMBER: begin
                  ev.event_kind = EV_NUMBER_DONE;
                  ev.number_value = sum;
               end
               default: begin
                  ev.event_kind = EV_ACK_DONE;
                  ev.ack_valid = &ack_hits;
               end
            endcase
         end else begin
            case (kind)
               FRAME_STRING: begin
                  if (kept < string_keep_limit()) begin
                     ev.event_kind = EV_STRING_BYTE;
                     ev.position = kept;
                     ev.char_byte = b;
                     produce = 1'b1;
                     kept = kept + 8'd1;
                  end
               end
               FRAME_NUMBER: begin
                  if (kept < number_keep_limit()) begin
                     // non-digits wrap the same way as digits
                     digit = {8'h00, b} - {8'h00, CHAR_DIGIT_ZERO};
                     sum = sum + digit * weight;
                     weight = weight * DIGIT_BASE;
                     kept = kept + 8'd1;
                  end
               end
               default: begin
                  if (kept < 8'(ACK_CHARS)) begin
                     if (b == ACK_WORD[kept[1:0]]) ack_hits[kept[1:0]] = 1'b1;
                     kept = kept + 8'd1;
                  end
               end
            endcase
         end
         if (produce) expected_events.push_back(ev);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
         if (seen !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
            errors++;
         end
      endfunction

      function void check_event(event_type got);
         event_type want;
         if (expected_events.size() == 0) begin
            $display("%0t: unexpected event, expected none, got kind %0d", $time,
                     got.event_kind);
            errors++;
            return;
         end
         want = expected_events.pop_front();
         compare_field("event_kind", 16'(want.event_kind), 16'(got.event_kind));
         compare_field("position", 16'(want.position), 16'(got.position));
         compare_field("char_byte", 16'(want.char_byte), 16'(got.char_byte));
         compare_field("string_length", 16'(want.string_length), 16'(got.string_length));
         compare_field("number_value", want.number_value, got.number_value);
         compare_field("ack_valid", 16'(want.ack_valid), 16'(got.ack_valid));
      endfunction
   endclass

   logic clock;
   logic reset;

   tfr_byte_if  req_ch ();
   tfr_event_if rsp_ch ();
   tfr_csr_if   csr_ch ();

   frame_scoreboard board = new();
   bit no_idle = 1'b0;
   bit long_hold_req = 1'b0;
   int frame_items = 0;
   int cycle_count = 0;

   typed_frame_receiver_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("typed_frame_receiver_unit_tb: errors");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   initial begin : result_sink
      int stall_left;
      int gap;
      event_type got;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.event_kind = event_kind_type'(rsp_ch.event_kind);
            got.position = rsp_ch.position;
            got.char_byte = rsp_ch.char_byte;
            got.string_length = rsp_ch.string_length;
            got.number_value = rsp_ch.number_value;
            got.ack_valid = rsp_ch.ack_valid;
            board.check_event(got);
         end
         if (long_hold_req) begin
            stall_left = LONG_HOLD_CYCLES;
            long_hold_req = 1'b0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            gap = no_idle ? 0 : idle_gap();
            if (gap > 0) begin
               stall_left = gap - 1;
               rsp_ch.ready <= 1'b0;
            end else begin
               rsp_ch.ready <= 1'b1;
            end
         end
      end
   end

   // valid stays high after the transfer; the caller drives it next in the same step
   task automatic send_byte(logic [7:0] value);
      int gap;
      gap = no_idle ? 0 : idle_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.rx_byte <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_byte(value);
   endtask

   task automatic write_capacity(csr_index_type idx, logic [8:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      board.write_capacity(idx, value);
   endtask

   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_frame(frame_kind_type kind, bit long_body);
      int len;
      int lim;
      bit genuine;
      logic [7:0] b;
      case (kind)
         FRAME_STRING: lim = int'(board.string_keep_limit());
         FRAME_NUMBER: lim = int'(board.number_keep_limit());
         default:      lim = ACK_CHARS;
      endcase
      genuine = 1'($urandom_range(0, 1));
      if (long_body) len = lim + 3;
      else if ($urandom_range(0, 99) < 80) len = $urandom_range(0, (lim < 10) ? lim + 2 : 10);
      else len = $urandom_range(0, lim + 3);
      case (kind)
         FRAME_STRING: send_byte(CHAR_OPEN_STRING);
         FRAME_NUMBER: send_byte(CHAR_OPEN_NUMBER);
         default:      send_byte(CHAR_OPEN_ACK);
      endcase
      for (int i = 0; i < len; i++) begin
         case (kind)
            FRAME_STRING: b = 8'($urandom_range(1, 255));
            FRAME_NUMBER: begin
               if ($urandom_range(0, 9) < 8) b = CHAR_DIGIT_ZERO + 8'($urandom_range(0, 9));
               else b = 8'($urandom_range(1, 255));
            end
            default: begin
               if (i < ACK_CHARS && genuine) b = ACK_WORD[i];
               else if (i < ACK_CHARS && $urandom_range(0, 1)) b = ACK_WORD[$urandom_range(0, 2)];
               else b = 8'($urandom_range(1, 255));
            end
         endcase
         send_byte(b);
      end
      send_byte(CHAR_CLOSE);
      frame_items += len + 2;
   endtask

   task automatic send_noise(bit raw);
      int n;
      logic [7:0] b;
      n = raw ? $urandom_range(1, 6) : $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
         b = 8'($urandom_range(0, 255));
         // plain noise keeps clear of frame openers, raw bursts may break into frames
         while (!raw && (b == CHAR_OPEN_STRING || b == CHAR_OPEN_NUMBER || b == CHAR_OPEN_ACK))
            b = 8'($urandom_range(0, 255));
         send_byte(b);
      end
      frame_items += n;
   endtask

   initial begin : stimulus
      int phase_end;
      int r;
      logic [8:0] scap;
      logic [3:0] ncap;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.rx_byte <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= CSR_STRING_CAPACITY;
      csr_ch.data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (OPENING_BYTES[i]) send_byte(OPENING_BYTES[i]);

      for (int phase = 0; frame_items < ITEM_TARGET; phase++) begin
         wait_for_results();
         no_idle = (phase % 4 == 3) || (phase == HOLD_PHASE);
         if (phase > 0) begin
            if (phase < PLAN_PHASES) begin
               scap = 9'(STRING_CAP_PLAN[phase]);
               ncap = 4'(NUMBER_CAP_PLAN[phase]);
            end else begin
               scap = $urandom_range(0, 1) ? 9'($urandom_range(0, 40)) : 9'($urandom_range(0, 511));
               ncap = 4'($urandom_range(0, 15));
            end
            write_capacity(CSR_STRING_CAPACITY, scap);
            write_capacity(CSR_NUMBER_CAPACITY, {5'd0, ncap});
            csr_ch.valid <= 1'b0;
         end
         // receiver stops for a while so the block backs up onto its input
         if (phase == HOLD_PHASE) long_hold_req = 1'b1;
         if (phase == LONG_STRING_PHASE) send_frame(FRAME_STRING, 1'b1);
         phase_end = frame_items + PHASE_ITEMS;
         while (frame_items < phase_end && frame_items < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 15) send_noise(1'b0);
            else if (r < 20) send_noise(1'b1);
            send_frame(frame_kind_type'($urandom_range(0, 2)), 1'b0);
         end
      end

      wait_for_results();
      if (board.errors == 0) begin
         $display("typed_frame_receiver_unit_tb: clean");
      end else begin
         $display("typed_frame_receiver_unit_tb: errors");
      end
      $finish;
   end

endmodule

// ===== typed_frame_receiver_unit.f =====
hw/rtl/tfr_pkg.sv
hw/rtl/tfr_channels.sv
hw/rtl/tfr_parser.sv
hw/rtl/tfr_rsp_buffer.sv
hw/rtl/typed_frame_receiver_unit.sv
test/typed_frame_receiver_unit_tb.sv
